// File: design/pit_pkg.sv
// shared types and constants for the interval timer and fm snoop block
`timescale 1ns / 1ps
`default_nettype none

package pit_pkg;

    // shared divider geometry
    localparam int DIV_W = 25;   // widest numerator: 231 * tick sum + remainder
    localparam int DSR_W = 17;   // widest divisor: 65536
    localparam int CNT_W = 5;    // holds a step count up to DIV_W
    localparam int SUM_W = 17;   // tick counter plus elapsed ticks

    localparam logic [CNT_W-1:0] STEPS_TICK = CNT_W'(SUM_W);

    // sample clock ratio
    localparam logic [7:0]       SMP_MUL = 8'd231;
    localparam logic [DSR_W-1:0] SMP_DIV = 17'd6250;

    // divide by 6250 as (x >> 1) / 3125: ceil(2^36 / 3125), exact below 2^25
    localparam int                RECIP_W   = 25;
    localparam int                SMP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] SMP_RECIP = 25'd21990233;

    // result saturation
    localparam logic [16:0] IRQ_MAX = 17'h1FFFF;
    localparam logic [28:0] ADD_MAX = 29'h1FFFFFFF;

    // i/o ports
    localparam logic [15:0] PORT_PIT_DATA0 = 16'h0040;
    localparam logic [15:0] PORT_PIT_CTRL  = 16'h0043;
    localparam logic [15:0] PORT_FM_SB     = 16'h0220;
    localparam logic [15:0] PORT_FM_SB2    = 16'h0228;
    localparam logic [15:0] PORT_FM_ADLIB  = 16'h0388;

    // control word fields
    localparam logic [7:0] CW_SEL_MASK = 8'hC0;
    localparam logic [7:0] CW_RW_MASK  = 8'h30;

    // item and result codes
    localparam logic OP_PORT_WRITE = 1'b0;
    localparam logic OP_ADVANCE    = 1'b1;
    localparam logic KIND_TIMER    = 1'b0;
    localparam logic KIND_FM       = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
        logic [CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DSR_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: design/pit_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module pit_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pit_pkg::t_div_req i_req,
    output pit_pkg::t_div_rsp      o_rsp
);

    logic [pit_pkg::DIV_W-1:0] r_quo, n_quo;
    logic [pit_pkg::DSR_W-1:0] r_rem, n_rem;
    logic [pit_pkg::DSR_W-1:0] r_divisor, n_divisor;
    logic [pit_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_done, n_done;

    logic [pit_pkg::DSR_W:0]   w_wide;
    logic [pit_pkg::DSR_W:0]   w_diff;

    // partial remainder with the next dividend bit shifted in
    assign w_wide = {r_rem, r_quo[pit_pkg::DIV_W-1]};
    assign w_diff = w_wide - {1'b0, r_divisor};

    always_comb begin
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        n_cnt     = r_cnt;
        n_done    = 1'b0;
        if (i_req.start) begin
            // left-align the dividend so its top bit goes first
            n_quo     = i_req.dividend << (pit_pkg::CNT_W'(pit_pkg::DIV_W) - i_req.steps);
            n_rem     = '0;
            n_divisor = i_req.divisor;
            n_cnt     = i_req.steps;
        end else if (r_cnt != '0) begin
            if (!w_diff[pit_pkg::DSR_W]) begin
                n_rem = w_diff[pit_pkg::DSR_W-1:0];
                n_quo = {r_quo[pit_pkg::DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_wide[pit_pkg::DSR_W-1:0];
                n_quo = {r_quo[pit_pkg::DIV_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == pit_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

// File: design/pit_timer_irq_sample_clock.sv
// top level: emulated timer channel 0 with fm port snoop and sample clock
// usage:
//   input channel (i_valid / o_stall) carries one transaction per item: a port
//   write (i_op = 0, i_port, i_wdata) or a timer advance (i_op = 1, i_ticks)
//   output channel (o_valid / i_stall) carries at most one result per item
// timing:
//   an fm port write places its result in the output register at the
//   accepting edge
//   a timer advance holds the input through a start, 17 divider steps for
//   tick sum / divider, taking the quotient, a multiply, a reciprocal
//   multiply for / 6250 and writing the result once the output register is free
//   no new transaction is taken while an advance is in flight
// stall:
//   a result waits in the output register while i_stall is high; the input
//   side is stalled only while that register is full and held, or while an
//   advance runs, so nothing is lost or repeated
// reset:
//   synchronous, active low; divider returns to 1 (zero means 65536), tick
//   counter, sample remainder, sample position and fm register latch clear
`timescale 1ns / 1ps
`default_nettype none

module pit_timer_irq_sample_clock #(
    parameter int TICK_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_op,
    input  wire logic [15:0] i_port,
    input  wire logic [7:0]  i_wdata,
    input  wire logic [15:0] i_ticks,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_kind,
    output logic [16:0]      o_irq_count,
    output logic [28:0]      o_samples_added,
    output logic [31:0]      o_sample_position,
    output logic             o_fm_is_data,
    output logic [7:0]       o_fm_reg,
    output logic [7:0]       o_fm_value
);

    // only the low tick bits count, and the port carries 16 of them
    localparam int TK_W = (TICK_WIDTH < 16) ? TICK_WIDTH : 16;
    localparam logic [15:0] TICK_MASK = 16'((64'd1 << TK_W) - 64'd1);
    localparam int PROD_W = pit_pkg::DIV_W - 1 + pit_pkg::RECIP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_TICK,
        S_MUL,
        S_DIV_SMP,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        LD_IDLE,
        LD_LOW,
        LD_HIGH
    } t_load;

    t_state r_state, n_state;
    t_load  r_load, n_load;

    // timer and sample clock state
    logic [15:0] r_divider, n_divider;
    logic [16:0] r_tick_cnt, n_tick_cnt;
    logic [12:0] r_smp_rem, n_smp_rem;
    logic [31:0] r_smp_total, n_smp_total;
    logic [7:0]  r_fm_latch, n_fm_latch;

    // advance working registers
    logic [pit_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [16:0]               r_irqs, n_irqs;
    logic [pit_pkg::DIV_W-1:0] r_smp_num, n_smp_num;
    logic [28:0]               r_added, n_added;

    // output register
    logic        r_out_valid, n_out_valid;
    logic        r_kind, n_kind;
    logic [16:0] r_irq_out, n_irq_out;
    logic [28:0] r_add_out, n_add_out;
    logic        r_fm_data, n_fm_data;
    logic [7:0]  r_fm_reg, n_fm_reg;
    logic [7:0]  r_fm_val, n_fm_val;

    pit_pkg::t_div_req w_req;
    pit_pkg::t_div_rsp w_rsp;

    logic                      w_in_acc;
    logic                      w_slot_free;
    logic [pit_pkg::DSR_W-1:0] w_eff_div;
    logic [pit_pkg::SUM_W-1:0] w_new_sum;
    logic [pit_pkg::DIV_W-1:0] w_smp_num;
    logic [PROD_W-1:0]         w_recip_prod;
    logic [pit_pkg::DIV_W-1:0] w_rem_full;
    logic                      w_arm;
    logic                      w_fm_port;

    assign w_slot_free = !r_out_valid || !i_stall;
    assign o_stall     = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign w_in_acc    = i_valid && !o_stall;

    // zero divider counts as 65536
    assign w_eff_div = (r_divider == '0) ? 17'h10000 : {1'b0, r_divider};
    assign w_new_sum = r_tick_cnt + {1'b0, i_ticks & TICK_MASK};

    // divider times irqs equals the consumed part of the tick sum
    assign w_smp_num = pit_pkg::DIV_W'(r_sum - r_tick_cnt) * pit_pkg::DIV_W'(pit_pkg::SMP_MUL)
                     + pit_pkg::DIV_W'(r_smp_rem);

    // samples = (num >> 1) / 3125 by reciprocal multiply, 24 by 25 bits
    assign w_recip_prod = PROD_W'(r_smp_num[pit_pkg::DIV_W-1:1])
                        * PROD_W'(pit_pkg::SMP_RECIP);

    // carried remainder: num - samples * 6250, always below 6250
    assign w_rem_full = r_smp_num
                      - pit_pkg::DIV_W'(r_added[12:0]) * pit_pkg::DIV_W'(pit_pkg::SMP_DIV);

    // control word: counter 0, low then high byte, binary
    assign w_arm = ((i_wdata & pit_pkg::CW_SEL_MASK) == 8'h00)
                && ((i_wdata & pit_pkg::CW_RW_MASK) == pit_pkg::CW_RW_MASK)
                && !i_wdata[0];

    assign w_fm_port = {i_port[15:1], 1'b0} inside
                       {pit_pkg::PORT_FM_SB, pit_pkg::PORT_FM_SB2, pit_pkg::PORT_FM_ADLIB};

    pit_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_load      = r_load;
        n_divider   = r_divider;
        n_tick_cnt  = r_tick_cnt;
        n_smp_rem   = r_smp_rem;
        n_smp_total = r_smp_total;
        n_fm_latch  = r_fm_latch;
        n_sum       = r_sum;
        n_irqs      = r_irqs;
        n_smp_num   = r_smp_num;
        n_added     = r_added;
        n_out_valid = r_out_valid && i_stall;
        n_kind      = r_kind;
        n_irq_out   = r_irq_out;
        n_add_out   = r_add_out;
        n_fm_data   = r_fm_data;
        n_fm_reg    = r_fm_reg;
        n_fm_val    = r_fm_val;

        w_req.start    = 1'b0;
        w_req.dividend = pit_pkg::DIV_W'(w_new_sum);
        w_req.divisor  = w_eff_div;
        w_req.steps    = pit_pkg::STEPS_TICK;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_op == pit_pkg::OP_ADVANCE) begin
                        // tick sum / divider on the divider unit
                        n_sum       = w_new_sum;
                        w_req.start = 1'b1;
                        n_state     = S_DIV_TICK;
                    end else if (i_port == pit_pkg::PORT_PIT_DATA0) begin
                        case (r_load)
                            LD_LOW: begin
                                n_divider = {r_divider[15:8], i_wdata};
                                n_load    = LD_HIGH;
                            end
                            LD_HIGH: begin
                                n_divider = {i_wdata, r_divider[7:0]};
                                n_load    = LD_IDLE;
                            end
                            default: begin
                                n_load = r_load;
                            end
                        endcase
                    end else if (i_port == pit_pkg::PORT_PIT_CTRL) begin
                        if (w_arm) begin
                            n_load = LD_LOW;
                        end
                    end else if (w_fm_port) begin
                        n_out_valid = 1'b1;
                        n_kind      = pit_pkg::KIND_FM;
                        n_irq_out   = '0;
                        n_add_out   = '0;
                        n_fm_val    = i_wdata;
                        n_fm_data   = i_port[0];
                        if (i_port[0]) begin
                            // data port reports the latch, then clears it
                            n_fm_reg   = r_fm_latch;
                            n_fm_latch = '0;
                        end else begin
                            n_fm_reg   = i_wdata;
                            n_fm_latch = i_wdata;
                        end
                    end
                end
            end
            S_DIV_TICK: begin
                if (w_rsp.done) begin
                    n_irqs     = (w_rsp.quo[pit_pkg::DIV_W-1:17] != '0)
                               ? pit_pkg::IRQ_MAX : w_rsp.quo[16:0];
                    n_tick_cnt = w_rsp.rem;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                // sample numerator with the carried remainder
                n_smp_num = w_smp_num;
                n_state   = S_DIV_SMP;
            end
            S_DIV_SMP: begin
                n_added = 29'(w_recip_prod[pit_pkg::SMP_SHIFT +: 13]);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_slot_free) begin
                    n_smp_rem   = w_rem_full[12:0];
                    n_smp_total = r_smp_total + 32'(r_added);
                    n_out_valid = 1'b1;
                    n_kind      = pit_pkg::KIND_TIMER;
                    n_irq_out   = r_irqs;
                    n_add_out   = (r_added > pit_pkg::ADD_MAX) ? pit_pkg::ADD_MAX : r_added;
                    n_fm_data   = 1'b0;
                    n_fm_reg    = '0;
                    n_fm_val    = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load      <= LD_IDLE;
            r_divider   <= 16'd1;
            r_tick_cnt  <= '0;
            r_smp_rem   <= '0;
            r_smp_total <= '0;
            r_fm_latch  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load      <= n_load;
            r_divider   <= n_divider;
            r_tick_cnt  <= n_tick_cnt;
            r_smp_rem   <= n_smp_rem;
            r_smp_total <= n_smp_total;
            r_fm_latch  <= n_fm_latch;
            r_out_valid <= n_out_valid;
        end
        r_sum     <= n_sum;
        r_irqs    <= n_irqs;
        r_smp_num <= n_smp_num;
        r_added   <= n_added;
        r_kind    <= n_kind;
        r_irq_out <= n_irq_out;
        r_add_out <= n_add_out;
        r_fm_data <= n_fm_data;
        r_fm_reg  <= n_fm_reg;
        r_fm_val  <= n_fm_val;
    end

    // sample position only moves when a result is written, so it tracks the output
    assign o_valid           = r_out_valid;
    assign o_kind            = r_kind;
    assign o_irq_count       = r_irq_out;
    assign o_samples_added   = r_add_out;
    assign o_sample_position = r_smp_total;
    assign o_fm_is_data      = r_fm_data;
    assign o_fm_reg          = r_fm_reg;
    assign o_fm_value        = r_fm_val;

endmodule

`default_nettype wire

// File: tb/tb_pit_timer_irq_sample_clock.sv
// testbench for the timer channel 0 block with fm port snoop and sample clock
`timescale 1ns / 1ps

module tb_pit_timer_irq_sample_clock;

    // run length and timing
    localparam int unsigned MAX_CYCLES   = 1_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;  // long receiver hold-off
    localparam int unsigned DRAIN_CYCLES = 64;   // settle time after the last owed result
    localparam int unsigned MAX_GAP      = 17;
    localparam int unsigned REPORT_LIMIT = 10;

    // divider load sequence, as the timer channel sees it
    typedef enum logic [1:0] {
        LOAD_IDLE = 2'd0,
        LOAD_LOW  = 2'd1,
        LOAD_HIGH = 2'd2
    } t_load_phase;

    // one result transaction, in port order
    typedef struct packed {
        logic        kind;
        logic [16:0] irq_count;
        logic [28:0] samples_added;
        logic [31:0] sample_position;
        logic        fm_is_data;
        logic [7:0]  fm_reg;
        logic [7:0]  fm_value;
    } t_timer_result;

    // block inputs, known from time zero
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_op    = 1'b0;
    logic [15:0] i_port  = 16'h0000;
    logic [7:0]  i_wdata = 8'h00;
    logic [15:0] i_ticks = 16'h0000;
    logic        i_stall = 1'b0;

    // block outputs
    logic        o_stall;
    logic        o_valid;
    logic        o_kind;
    logic [16:0] o_irq_count;
    logic [28:0] o_samples_added;
    logic [31:0] o_sample_position;
    logic        o_fm_is_data;
    logic [7:0]  o_fm_reg;
    logic [7:0]  o_fm_value;

    pit_timer_irq_sample_clock dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_op              (i_op),
        .i_port            (i_port),
        .i_wdata           (i_wdata),
        .i_ticks           (i_ticks),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_irq_count       (o_irq_count),
        .o_samples_added   (o_samples_added),
        .o_sample_position (o_sample_position),
        .o_fm_is_data      (o_fm_is_data),
        .o_fm_reg          (o_fm_reg),
        .o_fm_value        (o_fm_value)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the timer channel and sample clock state
    logic [15:0]  pit_divider;
    logic [16:0]  pit_ticks;
    t_load_phase  pit_load_phase;
    logic [12:0]  smp_remainder;
    logic [31:0]  smp_position;
    logic [7:0]   fm_latch;

    // results still owed by the block, oldest first
    t_timer_result owed_results[$];

    // idling control shared by the sender and the receiver
    int unsigned tx_max_gap = MAX_GAP;
    int unsigned rx_max_gap = MAX_GAP;
    int unsigned hold_requests = 0;

    // run statistics
    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned advances_seen  = 0;
    int unsigned fm_events_seen = 0;
    int unsigned divider_loads  = 0;
    int unsigned results_taken  = 0;

    // ------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------

    task automatic reset_timer_shadow();
        pit_divider    = 16'd1;
        pit_ticks      = '0;
        pit_load_phase = LOAD_IDLE;
        smp_remainder  = '0;
        smp_position   = '0;
        fm_latch       = '0;
    endtask

    // applies one accepted transaction to the shadow state and queues its result
    task automatic predict_item(input logic op, input logic [15:0] port,
                                input logic [7:0] wdata, input logic [15:0] ticks);
        t_timer_result   r;
        longint unsigned period;
        longint unsigned tick_sum;
        longint unsigned irqs;
        longint unsigned smp_sum;
        longint unsigned added;
        logic [15:0]     fm_base;
        r       = '0;
        fm_base = {port[15:1], 1'b0};
        if (op == pit_pkg::OP_ADVANCE) begin
            // zero divider is a full 65536 tick period
            period   = (pit_divider == 16'd0) ? 64'd65536 : 64'(pit_divider);
            tick_sum = 64'(pit_ticks) + 64'(ticks);
            irqs     = tick_sum / period;
            pit_ticks = 17'(tick_sum % period);
            // samples per interrupt: period * 231 / 6250, remainder carried
            smp_sum  = 64'(pit_pkg::SMP_MUL) * period * irqs + 64'(smp_remainder);
            added    = smp_sum / 64'(pit_pkg::SMP_DIV);
            smp_remainder = 13'(smp_sum % 64'(pit_pkg::SMP_DIV));
            smp_position  = smp_position + 32'(added);
            r.kind            = pit_pkg::KIND_TIMER;
            r.irq_count       = (irqs > 64'(pit_pkg::IRQ_MAX)) ? pit_pkg::IRQ_MAX : 17'(irqs);
            r.samples_added   = (added > 64'(pit_pkg::ADD_MAX)) ? pit_pkg::ADD_MAX
                                                                : 29'(added);
            r.sample_position = smp_position;
            owed_results.push_back(r);
            advances_seen++;
        end else if (port == pit_pkg::PORT_PIT_DATA0) begin
            case (pit_load_phase)
                LOAD_LOW: begin
                    pit_divider[7:0] = wdata;
                    pit_load_phase   = LOAD_HIGH;
                end
                LOAD_HIGH: begin
                    pit_divider[15:8] = wdata;
                    pit_load_phase    = LOAD_IDLE;
                    divider_loads++;
                end
                default: begin
                    // divider byte with no load armed is dropped
                end
            endcase
        end else if (port == pit_pkg::PORT_PIT_CTRL) begin
            // counter 0, low then high byte, binary counting arms the load
            if ((wdata & pit_pkg::CW_SEL_MASK) == 8'h00
                    && (wdata & pit_pkg::CW_RW_MASK) == pit_pkg::CW_RW_MASK
                    && wdata[0] == 1'b0) begin
                pit_load_phase = LOAD_LOW;
            end
        end else if (fm_base == pit_pkg::PORT_FM_SB || fm_base == pit_pkg::PORT_FM_SB2
                     || fm_base == pit_pkg::PORT_FM_ADLIB) begin
            r.kind            = pit_pkg::KIND_FM;
            r.sample_position = smp_position;
            r.fm_value        = wdata;
            if (port[0]) begin
                // data write reports the latched register, then clears it
                r.fm_is_data = 1'b1;
                r.fm_reg     = fm_latch;
                fm_latch     = 8'h00;
            end else begin
                fm_latch = wdata;
                r.fm_reg = wdata;
            end
            owed_results.push_back(r);
            fm_events_seen++;
        end
    endtask

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offers one transaction after a random gap and holds it until accepted;
    // valid stays high into the next call when that call draws no gap
    task automatic send_item(input logic op, input logic [15:0] port,
                             input logic [7:0] wdata, input logic [15:0] ticks);
        int unsigned gap;
        gap = $urandom_range(tx_max_gap, 0);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_port  <= port;
        i_wdata <= wdata;
        i_ticks <= ticks;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        predict_item(op, port, wdata, ticks);
        items_sent++;
    endtask

    // port write with noise on the unused tick field
    task automatic send_port(input logic [15:0] port, input logic [7:0] wdata);
        send_item(pit_pkg::OP_PORT_WRITE, port, wdata, 16'($urandom()));
    endtask

    // timer advance with noise on the unused port fields
    task automatic send_advance(input logic [15:0] ticks);
        send_item(pit_pkg::OP_ADVANCE, 16'($urandom()), 8'($urandom()), ticks);
    endtask

    function automatic logic [15:0] pick_divider();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return 16'($urandom_range(64, 1));
            4, 5, 6:    return 16'($urandom_range(4095, 65));
            7, 8:       return 16'($urandom());
            default:    return $urandom_range(1, 0) ? 16'h0000 : 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] pick_ticks();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return 16'($urandom_range(255, 0));
            8:          return 16'h0000;
            9:          return 16'hFFFF;
            default:    return 16'($urandom());
        endcase
    endfunction

    // counter 0, low/high access, binary, any mode
    function automatic logic [7:0] pick_arm_word();
        return {2'b00, 2'b11, 3'($urandom()), 1'b0};
    endfunction

    function automatic logic [15:0] pick_fm_base();
        case ($urandom_range(2, 0))
            0:       return pit_pkg::PORT_FM_SB;
            1:       return pit_pkg::PORT_FM_SB2;
            default: return pit_pkg::PORT_FM_ADLIB;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // receiver side
    // ------------------------------------------------------------------

    // draws a stall length after each accepted result; a hold request from the
    // test sequence forces one long stretch of stall
    int unsigned rx_wait = 0;
    int unsigned hold_served = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
        end else if (rx_wait != 0) begin
            rx_wait = rx_wait - 1;
            if (rx_wait == 0) begin
                i_stall <= 1'b0;
            end
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            rx_wait = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (o_valid === 1'b1 && i_stall == 1'b0) begin
            rx_wait = $urandom_range(rx_max_gap, 0);
            if (rx_wait != 0) begin
                i_stall <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string why, input t_timer_result want,
                                   input t_timer_result got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] %s", $time, why);
            $display("  expected kind=%0d irq=%0d added=%0d pos=%0d data=%0d reg=%02h val=%02h",
                     want.kind, want.irq_count, want.samples_added, want.sample_position,
                     want.fm_is_data, want.fm_reg, want.fm_value);
            $display("  actual   kind=%0d irq=%0d added=%0d pos=%0d data=%0d reg=%02h val=%02h",
                     got.kind, got.irq_count, got.samples_added, got.sample_position,
                     got.fm_is_data, got.fm_reg, got.fm_value);
        end
    endtask

    // compares every accepted result transaction with the oldest one owed
    always @(posedge i_clk) begin
        t_timer_result got;
        t_timer_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            got = {o_kind, o_irq_count, o_samples_added, o_sample_position,
                   o_fm_is_data, o_fm_reg, o_fm_value};
            results_taken++;
            if (owed_results.size() == 0) begin
                report_mismatch("result with nothing owed", '0, got);
            end else begin
                want = owed_results.pop_front();
                if (got !== want) begin
                    report_mismatch("result differs", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= MAX_CYCLES);
        $display("timeout after %0d cycles, %0d results still owed",
                 cycle_count, owed_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequences
    // ------------------------------------------------------------------

    // reset divider of 1: zero ticks still reports, full tick field fires
    // one interrupt per tick
    task automatic test_reset_defaults();
        send_advance(16'h0000);
        send_advance(16'hFFFF);
    endtask

    // address and data ports of the adlib and first sb pairs, data port only of
    // the second sb pair; a second data write sees the latch already cleared
    task automatic test_fm_ports();
        send_port(pit_pkg::PORT_FM_ADLIB, 8'hFF);
        send_port(pit_pkg::PORT_FM_ADLIB | 16'h0001, 8'h00);
        send_port(pit_pkg::PORT_FM_ADLIB | 16'h0001, 8'hAA);
        send_port(pit_pkg::PORT_FM_SB, 8'h00);
        send_port(pit_pkg::PORT_FM_SB | 16'h0001, 8'hFF);
        send_port(pit_pkg::PORT_FM_SB2 | 16'h0001, 8'h5A);
    endtask

    // stray divider byte first, then a zero divider that stands for 65536
    task automatic test_divider_load();
        send_port(pit_pkg::PORT_PIT_DATA0, 8'h12);
        send_port(pit_pkg::PORT_PIT_CTRL, 8'h34);
        send_port(pit_pkg::PORT_PIT_DATA0, 8'h00);
        send_port(pit_pkg::PORT_PIT_DATA0, 8'h00);
        send_advance(16'hFFFF);
        send_advance(16'hFFFF);
    endtask

    // control words that do not arm leave a load in progress alone
    task automatic test_control_words();
        send_port(pit_pkg::PORT_PIT_CTRL, 8'h34);
        send_port(pit_pkg::PORT_PIT_CTRL, 8'h35);  // bcd counting
        send_port(pit_pkg::PORT_PIT_CTRL, 8'h74);  // counter 1
        send_port(pit_pkg::PORT_PIT_CTRL, 8'hF4);  // read-back select
        send_port(pit_pkg::PORT_PIT_DATA0, 8'h05);
        send_port(pit_pkg::PORT_PIT_CTRL, 8'h20);  // high byte only access
        send_port(pit_pkg::PORT_PIT_DATA0, 8'h00);
        send_advance(16'd1000);
    endtask

    // counters 1 and 2 and unlisted ports give nothing
    task automatic test_ignored_ports();
        send_port(16'h0041, 8'hFF);
        send_port(16'h0042, 8'h00);
        send_port(16'hFFFF, 8'h55);
    endtask

    // receiver holds off while the sender keeps offering back to back, so the
    // output register fills and the input side stalls
    task automatic test_output_backpressure();
        tx_max_gap = 0;
        hold_requests++;
        for (int k = 0; k < 24; k++) begin
            if (k[0]) begin
                send_advance(pick_ticks());
            end else begin
                send_port(pick_fm_base() | 16'(k[1]), 8'($urandom()));
            end
        end
        tx_max_gap = MAX_GAP;
    endtask

    // mostly well formed traffic with random content, some broken divider
    // loads and some port noise that the block drops
    task automatic test_random_traffic(input int unsigned n_items, input int unsigned tx_gap,
                                       input int unsigned rx_gap);
        int unsigned done_items;
        int unsigned pick;
        logic [15:0] div_val;
        logic [15:0] fm_base;
        done_items = 0;
        tx_max_gap = tx_gap;
        rx_max_gap = rx_gap;
        while (done_items < n_items) begin
            pick = $urandom_range(99, 0);
            if (pick < 18) begin
                // divider load, occasionally interleaved or cut short
                div_val = pick_divider();
                send_port(pit_pkg::PORT_PIT_CTRL, pick_arm_word());
                if ($urandom_range(9, 0) == 0) begin
                    send_advance(pick_ticks());
                end
                send_port(pit_pkg::PORT_PIT_DATA0, div_val[7:0]);
                if ($urandom_range(9, 0) == 0) begin
                    send_port(pit_pkg::PORT_PIT_CTRL, 8'($urandom()));
                end
                if ($urandom_range(11, 0) != 0) begin
                    send_port(pit_pkg::PORT_PIT_DATA0, div_val[15:8]);
                end
                done_items += 3;
            end else if (pick < 58) begin
                send_advance(pick_ticks());
                done_items++;
            end else if (pick < 86) begin
                // fm register access: address then data, sometimes a lone data write
                fm_base = pick_fm_base();
                if ($urandom_range(4, 0) != 0) begin
                    send_port(fm_base, 8'($urandom()));
                    done_items++;
                end
                send_port(fm_base | 16'h0001, 8'($urandom()));
                done_items++;
            end else begin
                case ($urandom_range(3, 0))
                    0: send_port(16'($urandom()), 8'($urandom()));
                    1: send_port(pit_pkg::PORT_PIT_CTRL, 8'($urandom()));
                    2: send_port(pit_pkg::PORT_PIT_DATA0, 8'($urandom()));
                    default: send_port(pick_fm_base() + 16'($urandom_range(7, 2)),
                                       8'($urandom()));
                endcase
                done_items++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        reset_timer_shadow();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_fm_ports();
        test_divider_load();
        test_control_words();
        test_ignored_ports();
        test_output_backpressure();
        test_random_traffic(700, MAX_GAP, MAX_GAP);
        test_random_traffic(300, 0, 0);
        test_random_traffic(300, MAX_GAP, 0);
        test_random_traffic(400, 0, MAX_GAP);

        // drain: nothing more offered, wait for every owed result
        i_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions: %0d timer advances, %0d fm accesses, %0d divider loads",
                 items_sent, advances_seen, fm_events_seen, divider_loads);
        $display("%0d results checked under random and long receiver stalls, %0d mismatches",
                 results_taken, mismatch_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: sim.f
design/pit_pkg.sv
design/pit_div.sv
design/pit_timer_irq_sample_clock.sv
tb/tb_pit_timer_irq_sample_clock.sv
